// File: hdl/mme_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the matrix multiply engine.
// No dependencies; every other design file but mme_ram refers to it by scoped names.
package mme_pkg;

  // Sizing
  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = 3;                           // row / column field width
  localparam int DIM_W      = 4;                           // dimension register width
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int ACC_W      = 52;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic             wr_a;     // write load item into store A
    logic             wr_b;     // write load item into store B
    logic             rd_en;    // read one A/B pair for a product
    logic             rd_first; // first product of a dot product
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
    logic             emit;     // load the output register
    logic             last;     // final element of the product
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;  // products still in flight
    logic out_free;   // output register can take a new item
  } stat_t;

  // Clamp a written dimension to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Store address of element (row, col)
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
  endfunction

endpackage

// File: hdl/mme_req_if.sv
`timescale 1ns / 1ps
// Request channel: load and compute items with valid/ready handshake.
// Depends on mme_pkg for field widths.
interface mme_req_if;
  logic                                valid;
  logic                                ready;
  logic [mme_pkg::REQ_W-1:0]           req_type;
  logic [mme_pkg::IDX_W-1:0]           elem_row;
  logic [mme_pkg::IDX_W-1:0]           elem_col;
  logic signed [mme_pkg::DATA_WIDTH-1:0] elem_value;

  modport source (output valid, req_type, elem_row, elem_col, elem_value, input ready);
  modport sink   (input valid, req_type, elem_row, elem_col, elem_value, output ready);
endinterface

// File: hdl/mme_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: one product element per item, valid/ready handshake.
// Depends on mme_pkg for field widths.
interface mme_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [mme_pkg::IDX_W-1:0]             out_row;
  logic [mme_pkg::IDX_W-1:0]             out_col;
  logic signed [mme_pkg::DATA_WIDTH-1:0] product_value;
  logic                                  saturated;
  logic                                  last;

  modport source (output valid, out_row, out_col, product_value, saturated, last,
                  input ready);
  modport sink   (input valid, out_row, out_col, product_value, saturated, last,
                  output ready);
endinterface

// File: hdl/mme_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No dependencies.
module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/mme_ctrl.sv
`timescale 1ns / 1ps
// Controller: dimension registers, request decode and the row/column/inner
// sequencer. Depends on mme_pkg; drives mme_datapath through cmd_t.
module mme_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mme_pkg::DIM_W-1:0]      cfg_data_i,
  input  logic                           req_valid_i,
  input  logic [mme_pkg::REQ_W-1:0]      req_type_i,
  output logic                           req_ready_o,
  input  mme_pkg::stat_t                 stat_i,
  output mme_pkg::cmd_t                  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT
  } state_e;

  state_e                      state_q;
  logic [mme_pkg::DIM_W-1:0]   rows_q, inner_q, cols_q;
  logic [mme_pkg::IDX_W-1:0]   row_q, col_q, k_q;
  logic                        accept;
  logic                        last_k, last_row, last_col;

  // Counter end conditions against the dimension registers
  assign last_k   = (mme_pkg::DIM_W'(k_q) + mme_pkg::DIM_W'(1)) == inner_q;
  assign last_row = (mme_pkg::DIM_W'(row_q) + mme_pkg::DIM_W'(1)) == rows_q;
  assign last_col = (mme_pkg::DIM_W'(col_q) + mme_pkg::DIM_W'(1)) == cols_q;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  // Commands to the datapath
  always_comb begin
    cmd_o          = '0;
    cmd_o.wr_a     = accept && (req_type_i == mme_pkg::REQ_WRITE_A);
    cmd_o.wr_b     = accept && (req_type_i == mme_pkg::REQ_WRITE_B);
    cmd_o.rd_en    = (state_q == ST_READ);
    cmd_o.rd_first = (k_q == '0);
    cmd_o.row      = row_q;
    cmd_o.col      = col_q;
    cmd_o.k        = k_q;
    cmd_o.emit     = (state_q == ST_WAIT) && !stat_i.pipe_busy && stat_i.out_free;
    cmd_o.last     = last_row && last_col;
  end

  // Sequencer and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rows_q  <= mme_pkg::DIM_RESET;
      inner_q <= mme_pkg::DIM_RESET;
      cols_q  <= mme_pkg::DIM_RESET;
      row_q   <= '0;
      col_q   <= '0;
      k_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mme_pkg::CFG_ROWS_A:     rows_q  <= mme_pkg::clamp_dim(cfg_data_i);
          mme_pkg::CFG_INNER_SIZE: inner_q <= mme_pkg::clamp_dim(cfg_data_i);
          mme_pkg::CFG_COLS_B:     cols_q  <= mme_pkg::clamp_dim(cfg_data_i);
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept && (req_type_i == mme_pkg::REQ_COMPUTE)) begin
            row_q   <= '0;
            col_q   <= '0;
            k_q     <= '0;
            state_q <= ST_READ;
          end
        end
        // one A/B read pair per cycle
        ST_READ: begin
          if (last_k) begin
            k_q     <= '0;
            state_q <= ST_WAIT;
          end else begin
            k_q <= k_q + mme_pkg::IDX_W'(1);
          end
        end
        // drain the products, then hand the element to the output register
        ST_WAIT: begin
          if (cmd_o.emit) begin
            if (last_row && last_col) begin
              row_q   <= '0;
              col_q   <= '0;
              state_q <= ST_IDLE;
            end else if (last_col) begin
              col_q   <= '0;
              row_q   <= row_q + mme_pkg::IDX_W'(1);
              state_q <= ST_READ;
            end else begin
              col_q   <= col_q + mme_pkg::IDX_W'(1);
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/mme_datapath.sv
`timescale 1ns / 1ps
// Datapath: element stores, multiplier, accumulator, saturation and the
// output register. Depends on mme_pkg and mme_ram; controlled by mme_ctrl.
module mme_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mme_pkg::cmd_t                         cmd_i,
  output mme_pkg::stat_t                        stat_o,
  input  logic [mme_pkg::IDX_W-1:0]             elem_row_i,
  input  logic [mme_pkg::IDX_W-1:0]             elem_col_i,
  input  logic signed [mme_pkg::DATA_WIDTH-1:0] elem_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mme_pkg::IDX_W-1:0]             out_row_o,
  output logic [mme_pkg::IDX_W-1:0]             out_col_o,
  output logic signed [mme_pkg::DATA_WIDTH-1:0] product_value_o,
  output logic                                  saturated_o,
  output logic                                  last_o
);

  localparam int DW = mme_pkg::DATA_WIDTH;

  logic [mme_pkg::ADDR_W-1:0]      waddr, raddr_a, raddr_b;
  logic [DW-1:0]                   rdata_a, rdata_b;
  logic                            s1_vld_q, s1_first_q;
  logic                            s2_vld_q, s2_first_q;
  logic signed [mme_pkg::PROD_W-1:0] prod_d, prod_q, prod_shr;
  logic signed [mme_pkg::ACC_W-1:0]  acc_q, acc_base;
  logic                            sat_hi, sat_lo;
  logic signed [DW-1:0]            sat_value;
  logic                            out_vld_q;

  // Element stores
  assign waddr   = mme_pkg::elem_addr(elem_row_i, elem_col_i);
  assign raddr_a = mme_pkg::elem_addr(cmd_i.row, cmd_i.k);
  assign raddr_b = mme_pkg::elem_addr(cmd_i.k, cmd_i.col);

  mme_ram #(.WIDTH(DW), .DEPTH(mme_pkg::DEPTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a),
    .waddr_i (waddr),
    .wdata_i (elem_value_i),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mme_ram #(.WIDTH(DW), .DEPTH(mme_pkg::DEPTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b),
    .waddr_i (waddr),
    .wdata_i (elem_value_i),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // Multiply stage
  assign prod_d = $signed(rdata_a) * $signed(rdata_b);

  // Accumulate stage: arithmetic shift drops the fraction bits
  assign prod_shr = prod_q >>> mme_pkg::FRAC_BITS;
  assign acc_base = s2_first_q ? '0 : acc_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      s1_vld_q   <= cmd_i.rd_en;
      s1_first_q <= cmd_i.rd_first;
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      if (s2_vld_q) begin
        acc_q <= acc_base + prod_shr[mme_pkg::ACC_W-1:0];
      end
    end
  end

  // Saturate the sum to the data range
  assign sat_hi = !acc_q[mme_pkg::ACC_W-1] && (|acc_q[mme_pkg::ACC_W-2:DW-1]);
  assign sat_lo = acc_q[mme_pkg::ACC_W-1] && !(&acc_q[mme_pkg::ACC_W-2:DW-1]);

  always_comb begin
    priority if (sat_hi) begin
      sat_value = {1'b0, {(DW-1){1'b1}}};
    end else if (sat_lo) begin
      sat_value = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat_value = acc_q[DW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_row_o       <= cmd_i.row;
      out_col_o       <= cmd_i.col;
      product_value_o <= sat_value;
      saturated_o     <= sat_hi || sat_lo;
      last_o          <= cmd_i.last;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign stat_o.pipe_busy = s1_vld_q || s2_vld_q;
  assign stat_o.out_free  = !out_vld_q || out_ready_i;

endmodule

// File: hdl/matrix_multiply_engine_top.sv
`timescale 1ns / 1ps
// Top level of the matrix multiply engine: C = A * B in Q16.16.
// Depends on mme_pkg, mme_req_if, mme_rsp_if, mme_ctrl and mme_datapath.
//
//   port     kind          direction  payload
//   req_i    valid/ready   in         req_type, elem_row, elem_col, elem_value
//   rsp_o    valid/ready   out        out_row, out_col, product_value, saturated, last
//   cfg_*    write enable  in         rows_a, inner_size, cols_b (index 0..2)
//
// A load item (or an unknown request) is accepted while idle; loads stream back to back.
// A compute item walks the m*p elements, each with one store read pair per inner
// index through one multiplier, then a drain of the multiply and accumulate
// stages and a load of the output register.
// Results stall in the output register; a stall there holds the sequencer.
// Reset is asynchronous, active low; dimensions come up as 4, stores undefined.
module matrix_multiply_engine_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mme_req_if.sink                       req_i,
  mme_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mme_pkg::DIM_W-1:0]     cfg_data_i
);

  mme_pkg::cmd_t  cmd;
  mme_pkg::stat_t stat;

  // Sequencer
  mme_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Stores, arithmetic and output register
  mme_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .elem_row_i      (req_i.elem_row),
    .elem_col_i      (req_i.elem_col),
    .elem_value_i    (req_i.elem_value),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .out_row_o       (rsp_o.out_row),
    .out_col_o       (rsp_o.out_col),
    .product_value_o (rsp_o.product_value),
    .saturated_o     (rsp_o.saturated),
    .last_o          (rsp_o.last)
  );

endmodule

// File: verif/mme_gemm_checker_pkg.sv
`timescale 1ns / 1ps
// Item types and the product predictor used by the matrix multiply engine testbench.
// Depends on mme_pkg for widths, request codes and register indexes.
package mme_gemm_checker_pkg;
  import mme_pkg::*;

  // Request code the block ignores
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]             req_type;
    logic [IDX_W-1:0]             row;
    logic [IDX_W-1:0]             col;
    logic signed [DATA_WIDTH-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]             row;
    logic [IDX_W-1:0]             col;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         saturated;
    logic                         last;
  } elem_item_t;

  // Mirrors the matrices and dimensions, predicts every product element
  class gemm_checker;
    int unsigned                  dim_m;
    int unsigned                  dim_n;
    int unsigned                  dim_p;
    logic signed [DATA_WIDTH-1:0] mat_a [DEPTH];
    logic signed [DATA_WIDTH-1:0] mat_b [DEPTH];
    bit                           a_loaded [DEPTH];
    bit                           b_loaded [DEPTH];
    elem_item_t                   pending_elems [$];
    int unsigned                  mismatches;
    int unsigned                  elems_checked;
    int unsigned                  sat_seen;

    function new();
      dim_m = DIM_RESET;
      dim_n = DIM_RESET;
      dim_p = DIM_RESET;
      foreach (a_loaded[i]) begin
        a_loaded[i] = 1'b0;
        b_loaded[i] = 1'b0;
      end
      mismatches    = 0;
      elems_checked = 0;
      sat_seen      = 0;
    endfunction

    // Dimension write; out-of-range values pin to 1 or MAX_DIM
    function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      int unsigned v;
      if (data == '0) begin
        v = 1;
      end else if (data > MAX_DIM) begin
        v = MAX_DIM;
      end else begin
        v = data;
      end
      case (idx)
        CFG_ROWS_A:     dim_m = v;
        CFG_INNER_SIZE: dim_n = v;
        CFG_COLS_B:     dim_p = v;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_elems.size();
    endfunction

    // Row-major walk of C = A * B with floor shift per product and clipping
    function void multiply_matrices();
      longint     acc;
      longint     hi;
      longint     lo;
      elem_item_t e;
      hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
      lo = -hi - 1;
      for (int i = 0; i < dim_m; i++) begin
        for (int j = 0; j < dim_p; j++) begin
          acc = 0;
          for (int k = 0; k < dim_n; k++) begin
            acc += (longint'(mat_a[i * MAX_DIM + k]) * longint'(mat_b[k * MAX_DIM + j]))
                   >>> FRAC_BITS;
          end
          e.saturated = 1'b0;
          if (acc > hi) begin
            acc = hi;
            e.saturated = 1'b1;
          end else if (acc < lo) begin
            acc = lo;
            e.saturated = 1'b1;
          end
          e.row   = IDX_W'(i);
          e.col   = IDX_W'(j);
          e.value = DATA_WIDTH'(acc);
          e.last  = (i == dim_m - 1) && (j == dim_p - 1);
          pending_elems.push_back(e);
        end
      end
    endfunction

    // Accepted request item
    function void take_request(req_item_t it);
      int unsigned addr;
      addr = it.row * MAX_DIM + it.col;
      case (it.req_type)
        REQ_WRITE_A: begin
          mat_a[addr]    = it.value;
          a_loaded[addr] = 1'b1;
        end
        REQ_WRITE_B: begin
          mat_b[addr]    = it.value;
          b_loaded[addr] = 1'b1;
        end
        REQ_COMPUTE: multiply_matrices();
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [DATA_WIDTH-1:0] want,
                                logic [DATA_WIDTH-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Accepted result item against the oldest expected element
    function void check_element(elem_item_t got);
      elem_item_t want;
      if (pending_elems.size() == 0) begin
        $error("result element row %0d col %0d with none expected", got.row, got.col);
        mismatches++;
        return;
      end
      want = pending_elems.pop_front();
      elems_checked++;
      if (want.saturated) sat_seen++;
      compare_field("out_row", DATA_WIDTH'(want.row), DATA_WIDTH'(got.row));
      compare_field("out_col", DATA_WIDTH'(want.col), DATA_WIDTH'(got.col));
      compare_field("product_value", want.value, got.value);
      compare_field("saturated", DATA_WIDTH'(want.saturated), DATA_WIDTH'(got.saturated));
      compare_field("last", DATA_WIDTH'(want.last), DATA_WIDTH'(got.last));
    endfunction
  endclass

endpackage

// File: verif/matrix_multiply_engine_top_tb.sv
`timescale 1ns / 1ps
// Testbench for matrix_multiply_engine_top: random loads and computes, checked per element.
// Depends on mme_pkg, mme_req_if, mme_rsp_if and mme_gemm_checker_pkg.
module matrix_multiply_engine_top_tb;
  import mme_pkg::*;
  import mme_gemm_checker_pkg::*;

  localparam int ITEMS_TOTAL  = 400;
  localparam int SEGMENTS     = 4;     // dimension settings per idle phase
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIM_W-1:0]     cfg_data;

  mme_req_if req_ch ();
  mme_rsp_if rsp_ch ();

  matrix_multiply_engine_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  gemm_checker board = new();

  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 84;
  int          phase_no      = 0;
  int unsigned items_sent    = 0;
  int unsigned cfg_writes    = 0;
  int unsigned cycle_count   = 0;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Random element value: mostly small Q16.16, plenty of full range and extremes
  function automatic logic signed [DATA_WIDTH-1:0] rand_value();
    logic signed [DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = DATA_WIDTH'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
      4, 5, 6:    v = $urandom;
      7:          v = 32'h7FFF_FFFF;
      8:          v = 32'h8000_0000;
      default:    v = DATA_WIDTH'($urandom_range(0, 6)) - 3;
    endcase
    return v;
  endfunction

  // One request item, with random idle cycles ahead of it
  task automatic send_item(input req_item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid      = 1'b1;
    req_ch.req_type   = it.req_type;
    req_ch.elem_row   = it.row;
    req_ch.elem_col   = it.col;
    req_ch.elem_value = it.value;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    board.take_request(it);
    if (it.req_type != REQ_UNKNOWN) items_sent++;
  endtask

  task automatic send_load(input logic [REQ_W-1:0] kind, input int row, input int col,
                           input logic signed [DATA_WIDTH-1:0] value);
    req_item_t it;
    it.req_type = kind;
    it.row      = IDX_W'(row);
    it.col      = IDX_W'(col);
    it.value    = value;
    send_item(it);
  endtask

  // Compute item; rows and columns carry random noise the block ignores
  task automatic send_compute();
    send_load(REQ_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
  endtask

  // Load the operands a compute will read; fresh reloads all of them
  task automatic load_operands(input bit fresh);
    for (int i = 0; i < board.dim_m; i++)
      for (int k = 0; k < board.dim_n; k++)
        if (fresh || !board.a_loaded[i * MAX_DIM + k])
          send_load(REQ_WRITE_A, i, k, rand_value());
    for (int k = 0; k < board.dim_n; k++)
      for (int j = 0; j < board.dim_p; j++)
        if (fresh || !board.b_loaded[k * MAX_DIM + j])
          send_load(REQ_WRITE_B, k, j, rand_value());
  endtask

  // Wait for every expected element, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(posedge clk_i);
    board.set_dim(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] n,
                           input logic [DIM_W-1:0] p);
    write_reg(CFG_ROWS_A, m);
    write_reg(CFG_INNER_SIZE, n);
    write_reg(CFG_COLS_B, p);
  endtask

  // Mostly whole load-then-compute sequences, the rest noise and partial reloads
  task automatic run_segment(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        load_operands(1'b1);
        send_compute();
      end else if (pick < 80) begin
        send_load($urandom_range(0, 1) ? REQ_WRITE_B : REQ_WRITE_A,
                  $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
      end else if (pick < 87) begin
        send_load(REQ_UNKNOWN, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
      end else begin
        // partial reload of A, then a compute over mixed old and new data
        repeat ($urandom_range(1, 3))
          send_load(REQ_WRITE_A, $urandom_range(0, board.dim_m - 1),
                    $urandom_range(0, board.dim_n - 1), rand_value());
        load_operands(1'b0);
        send_compute();
      end
    end
  endtask

  function automatic logic [DIM_W-1:0] rand_dim();
    if ($urandom_range(0, 3) == 0) return DIM_W'($urandom_range(0, 15));
    return DIM_W'($urandom_range(1, 4));
  endfunction

  // Result side: random ready, one long hold-off in the last phase
  initial begin
    int  hold_left;
    bit  hold_done;
    elem_item_t got;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp_ch.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
      @(posedge clk_i);
      if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got.row       = rsp_ch.out_row;
        got.col       = rsp_ch.out_col;
        got.value     = rsp_ch.product_value;
        got.saturated = rsp_ch.saturated;
        got.last      = rsp_ch.last;
        board.check_element(got);
      end
      if (phase_no == 2 && !hold_done && rst_ni && rsp_ch.valid === 1'b1) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned seg_budget;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_ROWS_A;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_WRITE_A;
    req_ch.elem_row   = '0;
    req_ch.elem_col   = '0;
    req_ch.elem_value = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero dimensions pin to 1, unused index, saturation both ways,
    // floor rounding of a negative product, corner indexes, unknown request
    write_reg(CFG_IDX_W'(3), 4'hF);
    configure(4'd0, 4'd0, 4'd0);
    send_load(REQ_WRITE_A, 0, 0, 32'h7FFF_FFFF);
    send_load(REQ_WRITE_B, 0, 0, 32'h7FFF_FFFF);
    send_compute();
    send_load(REQ_WRITE_A, 0, 0, 32'h8000_0000);
    send_compute();
    send_load(REQ_WRITE_B, 0, 0, 32'h8000_0000);
    send_compute();
    send_load(REQ_WRITE_A, 0, 0, 32'hFFFF_FFFF);
    send_load(REQ_WRITE_B, 0, 0, 32'h0000_0001);
    send_compute();
    send_load(REQ_WRITE_A, 7, 7, 32'h0001_0000);
    send_load(REQ_WRITE_B, 7, 7, 32'h8000_0000);
    send_load(REQ_UNKNOWN, 7, 7, 32'h7FFF_FFFF);
    send_load(REQ_WRITE_A, 0, 0, 32'h0001_0000);
    send_load(REQ_WRITE_B, 0, 0, 32'h0001_8000);
    send_compute();
    settle();

    // Largest dimensions, values above the maximum pin to 8
    configure(4'd15, 4'd9, 4'd8);
    load_operands(1'b1);
    send_compute();
    settle();

    // Random phases: sender idles lightly, then heavily, then no idling at all
    for (int ph = 0; ph < 3; ph++) begin
      phase_no      = ph;
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 84 : 0;
      recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 24 : 0;
      for (int s = 0; s < SEGMENTS; s++) begin
        if (ph == 2 && s == 0) begin
          // deep inner dimension; its results start the long hold-off
          configure(4'd3, 4'd8, 4'd3);
          load_operands(1'b1);
          send_compute();
        end else begin
          configure(rand_dim(), rand_dim(), rand_dim());
        end
        // spread what is left of the item budget over the remaining segments
        seg_budget = (items_sent < ITEMS_TOTAL) ?
                     (ITEMS_TOTAL - items_sent) / (3 * SEGMENTS - (ph * SEGMENTS + s)) : 1;
        if (seg_budget == 0) seg_budget = 1;
        run_segment(seg_budget);
        settle();
      end
    end

    $display("Sent %0d request items over %0d register writes and three idle phases;",
             items_sent, cfg_writes);
    $display("checked %0d product elements, %0d of them clipped.",
             board.elems_checked, board.sat_seen);
    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
